// File: rtl/core/twgmp_pkg.sv
// Shared types and constants for the two-walker grid max-path block.
// No dependencies; compile first.
package twgmp_pkg;

   localparam int CELL_W  = 8;
   localparam int SCORE_W = 24;
   localparam int SUM_W   = SCORE_W + 1;
   localparam int GAIN_W  = CELL_W + 1;
   localparam int NCOLS_W = 5;

   localparam logic [NCOLS_W-1:0] NCOLS_RESET = NCOLS_W'(16);
   localparam logic [SCORE_W-1:0] SCORE_MAX   = '1;

   typedef struct packed {
      logic               reach;
      logic [SCORE_W-1:0] score;
   } pair_entry_type;

   typedef struct packed {
      logic start;
      logic first_row;
      logic clear_max;
   } sweep_ctrl_type;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SWEEP  = 4'b0010,
      ST_REDUCE = 4'b0100,
      ST_EMIT   = 4'b1000
   } state_type;

endpackage

// File: rtl/core/twgmp_channels_if.sv
// Valid/ready channel interfaces for cell input and result output.
// Depends on twgmp_pkg.
interface twgmp_req_if import twgmp_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CELL_W-1:0] cell_value;
   logic              last_cell;

   modport source (output valid, cell_value, last_cell, input ready);
   modport sink   (input valid, cell_value, last_cell, output ready);
endinterface

interface twgmp_rsp_if import twgmp_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [SCORE_W-1:0] best_total;
   logic               incomplete_row;

   modport source (output valid, best_total, incomplete_row, input ready);
   modport sink   (input valid, best_total, incomplete_row, output ready);
endinterface

// File: rtl/core/twgmp_pair_ram.sv
// Simple dual-port synchronous RAM, one write and one registered read per cycle.
// No dependencies.
module twgmp_pair_ram #(
   parameter int DATA_W = 400,
   parameter int DEPTH  = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [DATA_W-1:0]        wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [DATA_W-1:0]        rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/twgmp_sweep.sv
// Row sweep of the pair score table: streams old rows from one RAM bank through a
// three-row window, takes the max-plus step and writes new rows to the other bank.
// Depends on twgmp_pkg.
module twgmp_sweep import twgmp_pkg::*; #(
   parameter int MAX_COLS = 16
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  sweep_ctrl_type                             ctrl,
   input  logic [$clog2(MAX_COLS+1)-1:0]              row_width,
   input  logic [$clog2(MAX_COLS+1)-1:0]              read_limit,
   input  logic                                       old_bank,
   input  logic [CELL_W-1:0]                          cells [MAX_COLS],
   output logic                                       mem_rd_en,
   output logic [$clog2(2*MAX_COLS)-1:0]              mem_rd_addr,
   input  logic [MAX_COLS*$bits(pair_entry_type)-1:0] mem_rd_data,
   output logic                                       mem_wr_en,
   output logic [$clog2(2*MAX_COLS)-1:0]              mem_wr_addr,
   output logic [MAX_COLS*$bits(pair_entry_type)-1:0] mem_wr_data,
   output logic [SCORE_W-1:0]                         lane_max [MAX_COLS],
   output logic                                       done
);

   localparam int IW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int CW = $clog2(MAX_COLS + 1);
   localparam int AW = $clog2(2 * MAX_COLS);

   logic           rd_v_ff, dat_v_ff, win_v_ff, vm_v_ff;
   logic [CW-1:0]  rd_idx_ff, dat_idx_ff, win_idx_ff;
   logic [CW-1:0]  m_ff, read_lim_ff;
   logic           first_ff;
   logic [IW-1:0]  vm_a_ff;
   logic [CW-1:0]  win_idx_dec;
   logic [IW-1:0]  rd_row_sel;

   pair_entry_type win_ff  [3][MAX_COLS];
   pair_entry_type vmax_ff [MAX_COLS];
   pair_entry_type vmax_in [MAX_COLS];
   pair_entry_type hbest   [MAX_COLS];
   pair_entry_type load_row[MAX_COLS];
   logic [SCORE_W-1:0] lane_max_ff [MAX_COLS];
   logic [GAIN_W-1:0]  gain [MAX_COLS];
   logic [SCORE_W-1:0] base [MAX_COLS];
   logic [SUM_W-1:0]   sum  [MAX_COLS];
   logic [CELL_W-1:0]  cell_a;

   pair_entry_type [MAX_COLS-1:0] rd_row;
   pair_entry_type [MAX_COLS-1:0] new_row;

   function automatic pair_entry_type entry_max(input pair_entry_type x,
                                                input pair_entry_type y);
      pair_entry_type r;
      if (!x.reach) begin
         r = y;
      end else if (!y.reach) begin
         r = x;
      end else if (y.score > x.score) begin
         r = y;
      end else begin
         r = x;
      end
      return r;
   endfunction

   assign rd_row      = mem_rd_data;
   assign win_idx_dec = win_idx_ff - CW'(1);
   assign rd_row_sel  = (rd_idx_ff < CW'(MAX_COLS)) ? rd_idx_ff[IW-1:0] : '0;

   assign mem_rd_en   = rd_v_ff;
   assign mem_rd_addr = old_bank ? AW'(MAX_COLS) + AW'(rd_row_sel) : AW'(rd_row_sel);
   assign mem_wr_en   = vm_v_ff;
   assign mem_wr_addr = old_bank ? AW'(vm_a_ff) : AW'(MAX_COLS) + AW'(vm_a_ff);
   assign mem_wr_data = new_row;
   assign lane_max    = lane_max_ff;
   assign done        = vm_v_ff && (CW'(vm_a_ff) == m_ff - CW'(1));

   always_comb begin
      cell_a = cells[vm_a_ff];
      for (int b = 0; b < MAX_COLS; b++) begin
         load_row[b].reach = rd_row[b].reach && (dat_idx_ff < read_lim_ff) && (b < m_ff);
         load_row[b].score = rd_row[b].score;

         vmax_in[b] = entry_max(entry_max(win_ff[0][b], win_ff[1][b]), win_ff[2][b]);

         hbest[b] = vmax_ff[b];
         if (b > 0) begin
            hbest[b] = entry_max(hbest[b], vmax_ff[b-1]);
         end
         if (b < MAX_COLS - 1) begin
            hbest[b] = entry_max(hbest[b], vmax_ff[b+1]);
         end

         // shared cell counts once
         if (b == vm_a_ff) begin
            gain[b] = GAIN_W'(cell_a);
         end else begin
            gain[b] = GAIN_W'(cell_a) + GAIN_W'(cells[b]);
         end
         base[b] = first_ff ? '0 : hbest[b].score;
         sum[b]  = SUM_W'(base[b]) + SUM_W'(gain[b]);

         new_row[b].score = (sum[b] > SUM_W'(SCORE_MAX)) ? SCORE_MAX : sum[b][SCORE_W-1:0];
         if (first_ff) begin
            new_row[b].reach = (vm_a_ff == '0) && (b == m_ff - 1);
         end else begin
            new_row[b].reach = hbest[b].reach && (b < m_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_v_ff  <= 1'b0;
         dat_v_ff <= 1'b0;
         win_v_ff <= 1'b0;
         vm_v_ff  <= 1'b0;
         for (int b = 0; b < MAX_COLS; b++) begin
            lane_max_ff[b] <= '0;
         end
      end else begin
         if (ctrl.start) begin
            rd_v_ff <= 1'b1;
         end else if (rd_v_ff && (rd_idx_ff == m_ff)) begin
            rd_v_ff <= 1'b0;
         end
         dat_v_ff <= rd_v_ff;
         win_v_ff <= dat_v_ff;
         vm_v_ff  <= win_v_ff && (win_idx_ff != '0);
         for (int b = 0; b < MAX_COLS; b++) begin
            if (ctrl.start || ctrl.clear_max) begin
               lane_max_ff[b] <= '0;
            end else if (vm_v_ff && new_row[b].reach && (new_row[b].score > lane_max_ff[b])) begin
               lane_max_ff[b] <= new_row[b].score;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.start) begin
         rd_idx_ff   <= '0;
         m_ff        <= row_width;
         read_lim_ff <= read_limit;
         first_ff    <= ctrl.first_row;
      end else if (rd_v_ff) begin
         rd_idx_ff <= rd_idx_ff + CW'(1);
      end
      dat_idx_ff <= rd_idx_ff;
      win_idx_ff <= dat_idx_ff;
      vm_a_ff    <= win_idx_dec[IW-1:0];
      for (int b = 0; b < MAX_COLS; b++) begin
         vmax_ff[b] <= vmax_in[b];
         if (ctrl.start) begin
            win_ff[0][b].reach <= 1'b0;
            win_ff[1][b].reach <= 1'b0;
            win_ff[2][b].reach <= 1'b0;
         end else if (dat_v_ff) begin
            win_ff[0][b] <= win_ff[1][b];
            win_ff[1][b] <= win_ff[2][b];
            win_ff[2][b] <= load_row[b];
         end
      end
   end

endmodule

// File: rtl/core/two_walker_grid_max_path.sv
// Top level of the two-walker grid max-path block: control, row buffer, result reduce.
// Depends on twgmp_pkg, twgmp_channels_if, twgmp_pair_ram, twgmp_sweep.
//
//   channel    dir   handshake               payload
//   req_chan   in    valid/ready             cell_value[7:0], last_cell
//   rsp_chan   out   valid/ready             best_total[23:0], incomplete_row
//   csr        in    csr_wr_en (no stall)    csr_wr_data[4:0] = num_cols
//
// A cell that does not end a row is stored in the row buffer. A cell that ends a row starts a sweep
// of the pair RAM, one table row per cycle.
// The final cell then runs the lane maximum reduce over all MAX_COLS lanes and loads the
// result register. The result register lets a new grid start while a result waits.
// Reset is synchronous; the pair RAM needs no clearing pass (a row count masks it).
module two_walker_grid_max_path import twgmp_pkg::*; #(
   parameter int MAX_COLS = 16
) (
   input  logic               clock,
   input  logic               reset,
   twgmp_req_if.sink          req_chan,
   twgmp_rsp_if.source        rsp_chan,
   input  logic               csr_wr_en,
   input  logic [NCOLS_W-1:0] csr_wr_data
);

   localparam int IW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int CW    = $clog2(MAX_COLS + 1);
   localparam int DEPTH = 2 * MAX_COLS;
   localparam int AW    = $clog2(DEPTH);
   localparam int ROW_W = MAX_COLS * $bits(pair_entry_type);

   state_type state_ff, state_in;

   logic [NCOLS_W-1:0] num_cols_ff;
   logic [IW-1:0]      count_ff;
   logic               first_row_ff;
   logic [CW-1:0]      valid_m_ff;
   logic               bank_ff;
   logic               pend_last_ff;
   logic               incomplete_ff;
   logic [CW-1:0]      pass_m_ff;
   logic [IW-1:0]      red_idx_ff;
   logic [SCORE_W-1:0] red_best_ff;
   logic               rsp_valid_ff;
   logic [SCORE_W-1:0] rsp_best_ff;
   logic               rsp_inc_ff;
   logic [CELL_W-1:0]  cells_ff [MAX_COLS];

   logic [CW-1:0]      m_cur;
   logic [CW-1:0]      limit;
   logic [CW-1:0]      cnt_next;
   logic               row_done;
   logic               accept;
   logic               emit_load;
   logic               sweep_done;
   sweep_ctrl_type     sweep_ctrl;
   logic [SCORE_W-1:0] lane_max [MAX_COLS];

   logic               mem_rd_en, mem_wr_en;
   logic [AW-1:0]      mem_rd_addr, mem_wr_addr;
   logic [ROW_W-1:0]   mem_rd_data, mem_wr_data;

   always_comb begin
      if (num_cols_ff == '0) begin
         m_cur = CW'(1);
      end else if (32'(num_cols_ff) > MAX_COLS) begin
         m_cur = CW'(MAX_COLS);
      end else begin
         m_cur = CW'(num_cols_ff);
      end
   end

   assign limit    = first_row_ff ? '0 : ((m_cur < valid_m_ff) ? m_cur : valid_m_ff);
   assign cnt_next = CW'(count_ff) + CW'(1);
   assign row_done = cnt_next >= m_cur;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign accept         = req_chan.valid && req_chan.ready;
   assign emit_load      = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_chan.ready);

   assign sweep_ctrl.start     = accept && row_done;
   assign sweep_ctrl.first_row = first_row_ff;
   assign sweep_ctrl.clear_max = emit_load;

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.best_total     = rsp_best_ff;
   assign rsp_chan.incomplete_row = rsp_inc_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (row_done) begin
                  state_in = ST_SWEEP;
               end else if (req_chan.last_cell) begin
                  state_in = ST_REDUCE;
               end
            end
         end
         ST_SWEEP: begin
            if (sweep_done) begin
               state_in = pend_last_ff ? ST_REDUCE : ST_IDLE;
            end
         end
         ST_REDUCE: begin
            if (red_idx_ff == IW'(MAX_COLS - 1)) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (emit_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         num_cols_ff  <= NCOLS_RESET;
         count_ff     <= '0;
         first_row_ff <= 1'b1;
         valid_m_ff   <= '0;
         bank_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) begin
            num_cols_ff <= csr_wr_data;
         end
         if (accept) begin
            count_ff <= (row_done || req_chan.last_cell) ? '0 : cnt_next[IW-1:0];
         end
         if (emit_load) begin
            first_row_ff <= 1'b1;
            valid_m_ff   <= '0;
         end else if (sweep_done) begin
            first_row_ff <= 1'b0;
            valid_m_ff   <= pass_m_ff;
         end
         if (sweep_done) begin
            bank_ff <= ~bank_ff;
         end
         if (emit_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cells_ff[count_ff] <= req_chan.cell_value;
         pend_last_ff       <= req_chan.last_cell;
         incomplete_ff      <= !row_done;
         pass_m_ff          <= m_cur;
      end
      if ((state_in == ST_REDUCE) && (state_ff != ST_REDUCE)) begin
         red_idx_ff  <= '0;
         red_best_ff <= '0;
      end else if (state_ff == ST_REDUCE) begin
         red_idx_ff <= red_idx_ff + IW'(1);
         if (lane_max[red_idx_ff] > red_best_ff) begin
            red_best_ff <= lane_max[red_idx_ff];
         end
      end
      if (emit_load) begin
         rsp_best_ff <= red_best_ff;
         rsp_inc_ff  <= incomplete_ff;
      end
   end

   twgmp_pair_ram #(
      .DATA_W (ROW_W),
      .DEPTH  (DEPTH)
   ) u_pair_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   twgmp_sweep #(
      .MAX_COLS (MAX_COLS)
   ) u_sweep (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (sweep_ctrl),
      .row_width   (m_cur),
      .read_limit  (limit),
      .old_bank    (bank_ff),
      .cells       (cells_ff),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .lane_max    (lane_max),
      .done        (sweep_done)
   );

endmodule
